FILE: design/pigv_pkg.sv
package pigv_pkg;

  // geometry of the tracked device
  localparam int unsigned PAGES_PER_BLOCK = 256;
  localparam int unsigned TOTAL_BLOCKS    = 256;
  localparam int unsigned SET_BLOCKS      = 64;
  localparam int unsigned CAPACITY        = TOTAL_BLOCKS * PAGES_PER_BLOCK;

  // field widths
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned PAGE_OFF_W = $clog2(PAGES_PER_BLOCK);
  localparam int unsigned BLK_W      = ADDR_W - PAGE_OFF_W;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned FIRST_W    = 8;
  localparam int unsigned BCNT_W     = 7;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SCAN_W     = $clog2(SET_BLOCKS + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

  // item actions
  localparam logic ACT_INVALIDATE = 1'b0;
  localparam logic ACT_ERASE      = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
    logic scan;
    logic emit;
  } pigv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_busy;
  } pigv_status_t;

endpackage

FILE: design/pigv_ctrl.sv
module pigv_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  pigv_pkg::pigv_status_t status,
  output pigv_pkg::pigv_cmd_t    cmd,
  output logic                  in_stall
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_WRITE = 6'b000100,
    S_SCAN  = 6'b001000,
    S_LAST  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_next  = status.hit ? S_READ : S_SCAN;
        end
      end
      S_READ: begin
        cmd.lookup = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.update = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/pigv_dp.sv
module pigv_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pigv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pigv_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 action,
  input  logic [pigv_pkg::ADDR_W-1:0]          page_address,
  input  logic [pigv_pkg::IDX_W-1:0]           block_index,
  input  pigv_pkg::pigv_cmd_t                  cmd,
  output pigv_pkg::pigv_status_t               status,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 address_error,
  output logic                                 page_was_valid,
  output logic                                 victim_found,
  output logic [pigv_pkg::IDX_W-1:0]           victim_index,
  output logic [pigv_pkg::CNT_W-1:0]           victim_invalid_count,
  output logic                                 victim_fully_invalid
);

  localparam int unsigned PPB    = pigv_pkg::PAGES_PER_BLOCK;
  localparam int unsigned NBLK   = pigv_pkg::SET_BLOCKS;
  localparam int unsigned ADDR_W = pigv_pkg::ADDR_W;
  localparam int unsigned OFF_W  = pigv_pkg::PAGE_OFF_W;
  localparam int unsigned BLK_W  = pigv_pkg::BLK_W;
  localparam int unsigned IDX_W  = pigv_pkg::IDX_W;
  localparam int unsigned CNT_W  = pigv_pkg::CNT_W;
  localparam int unsigned BCNT_W = pigv_pkg::BCNT_W;
  localparam int unsigned SCAN_W = pigv_pkg::SCAN_W;
  localparam logic [ADDR_W:0]   CAP_LIMIT = (ADDR_W + 1)'(pigv_pkg::CAPACITY);
  localparam logic [BCNT_W-1:0] MAX_TRACK = BCNT_W'(NBLK);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(PPB);

  // configuration
  logic [pigv_pkg::FIRST_W-1:0] first_block;
  logic [BCNT_W-1:0]            block_count;
  logic [BCNT_W-1:0]            tracked;

  // item decode
  logic [BLK_W-1:0]  in_blk;
  logic [BLK_W-1:0]  in_rel;
  logic              in_addr_err;
  logic              in_range;
  logic              in_hit;
  logic              in_erase_ok;

  // item registers
  logic              addr_err_q;
  logic              was_valid_q;
  logic [IDX_W-1:0]  idx_q;
  logic [OFF_W-1:0]  off_q;

  // storage
  logic [PPB-1:0]    row_mem [NBLK];
  logic [CNT_W-1:0]  cnt_mem [NBLK];
  logic [NBLK-1:0]   row_ok;
  logic [NBLK-1:0]   cnt_ok;
  logic [PPB-1:0]    row_rd;
  logic [CNT_W-1:0]  cnt_rd;
  logic              cnt_ok_rd;
  logic [IDX_W-1:0]  rd_addr;

  // update path
  logic [PPB-1:0]    cur_row;
  logic [PPB-1:0]    row_wr;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  cnt_wr;
  logic              page_set;
  logic              do_write;

  // victim scan
  logic [SCAN_W-1:0] sc;
  logic              cmp_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [CNT_W-1:0]  best;
  logic [IDX_W-1:0]  best_idx;

  assign tracked = (block_count > MAX_TRACK) ? MAX_TRACK : block_count;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_block <= '0;
      block_count <= MAX_TRACK;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pigv_pkg::CFG_FIRST_BLOCK: first_block <= cfg_data;
        pigv_pkg::CFG_BLOCK_COUNT: block_count <= cfg_data[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // decode the incoming item
  assign in_blk      = page_address[ADDR_W-1:OFF_W];
  assign in_rel      = in_blk - BLK_W'(first_block);
  assign in_addr_err = (action == pigv_pkg::ACT_INVALIDATE) &&
                       ({1'b0, page_address} >= CAP_LIMIT);
  assign in_range    = (in_blk >= BLK_W'(first_block)) && (in_rel < BLK_W'(tracked));
  assign in_hit      = (action == pigv_pkg::ACT_INVALIDATE) && !in_addr_err && in_range;
  assign in_erase_ok = (action == pigv_pkg::ACT_ERASE) && (BCNT_W'(block_index) < tracked);

  assign status.hit = in_hit;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_err_q <= in_addr_err;
      idx_q      <= (action == pigv_pkg::ACT_ERASE) ? block_index : in_rel[IDX_W-1:0];
      off_q      <= page_address[OFF_W-1:0];
    end
  end

  // memory read port: lookup row or scan counter
  assign rd_addr = cmd.lookup ? idx_q : sc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    row_rd    <= row_mem[rd_addr];
    cnt_rd    <= cnt_mem[rd_addr];
    cnt_ok_rd <= cnt_ok[rd_addr];
  end

  // read-modify-write of the page map and counter
  assign cur_row  = row_ok[idx_q] ? row_rd : '1;
  assign page_set = cur_row[off_q];
  assign row_wr   = cur_row & ~({{(PPB-1){1'b0}}, 1'b1} << off_q);
  assign cur_cnt  = cnt_ok_rd ? cnt_rd : '0;
  assign cnt_wr   = cur_cnt + CNT_W'(1);
  assign do_write = cmd.update && page_set;

  always_ff @(posedge clk) begin
    if (do_write) begin
      row_mem[idx_q] <= row_wr;
      cnt_mem[idx_q] <= cnt_wr;
    end
  end

  // per-block entry valid flags, an erase drops back to all valid and zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      cnt_ok <= '0;
    end else if (cmd.capture && in_erase_ok) begin
      row_ok[block_index] <= 1'b0;
      cnt_ok[block_index] <= 1'b0;
    end else if (do_write) begin
      row_ok[idx_q] <= 1'b1;
      cnt_ok[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      was_valid_q <= 1'b0;
    end else if (do_write) begin
      was_valid_q <= 1'b1;
    end
  end

  // scan counter and compare pipeline
  assign status.scan_done = ({1'b0, sc} + (SCAN_W + 1)'(1)) >= (SCAN_W + 1)'(tracked);

  always_ff @(posedge clk) begin
    if (rst) begin
      sc    <= '0;
      cmp_q <= 1'b0;
    end else begin
      if (cmd.capture) begin
        sc <= '0;
      end else if (cmd.scan) begin
        sc <= sc + SCAN_W'(1);
      end
      cmp_q <= cmd.scan && ((SCAN_W + 1)'(sc) < (SCAN_W + 1)'(tracked));
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_q <= sc[IDX_W-1:0];
  end

  // running maximum, first block wins ties
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      best     <= '0;
      best_idx <= '0;
    end else if (cmp_q && (cnt_ok_rd ? cnt_rd : '0) > best) begin
      best     <= cnt_rd;
      best_idx <= cmp_idx_q;
    end
  end

  // output register
  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      address_error        <= addr_err_q;
      page_was_valid       <= was_valid_q;
      victim_found         <= (best != '0);
      victim_index         <= best_idx;
      victim_invalid_count <= best;
      victim_fully_invalid <= (best == FULL_CNT);
    end
  end

endmodule

FILE: design/page_invalidation_greedy_victim_core.sv
// Page validity tracker with greedy victim selection for one segment of
// consecutive erase blocks.
// Input channel (in_valid / in_stall): one item per transfer, either an
// invalidate of page_address or an erase of segment block block_index.
// Output channel (out_valid / out_stall): exactly one result per item,
// carrying the invalidate outcome and the current greedy victim.
// Config port: cfg_write with cfg_index 0 sets first_block, 1 sets block_count;
// write only while no item is in flight.
// Sequence: an item is captured in IDLE, passes READ and WRITE only for an
// invalidate in range, then SCAN over the tracked blocks (tracked being the
// saturated block_count), then LAST and EMIT, which waits while the output is busy.
// The counter scan reads one block counter per cycle from the counter memory
// and so sets how long an item takes; one item is in flight at a time.
// Reset: every page valid, every counter zero (per-block flags, no clearing
// pass), first_block 0, block_count 64; no result pending.
// Stall: a result waits in the output register; the next item is taken
// meanwhile and its own result waits until that register is free.
module page_invalidation_greedy_victim_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pigv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pigv_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [pigv_pkg::ADDR_W-1:0]       page_address,
  input  logic [pigv_pkg::IDX_W-1:0]        block_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              address_error,
  output logic                              page_was_valid,
  output logic                              victim_found,
  output logic [pigv_pkg::IDX_W-1:0]        victim_index,
  output logic [pigv_pkg::CNT_W-1:0]        victim_invalid_count,
  output logic                              victim_fully_invalid
);

  pigv_pkg::pigv_cmd_t    cmd;
  pigv_pkg::pigv_status_t status;

  // sequencer
  pigv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // page map, counters and victim scan
  pigv_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_write            (cfg_write),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .action               (action),
    .page_address         (page_address),
    .block_index          (block_index),
    .cmd                  (cmd),
    .status               (status),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .address_error        (address_error),
    .page_was_valid       (page_was_valid),
    .victim_found         (victim_found),
    .victim_index         (victim_index),
    .victim_invalid_count (victim_invalid_count),
    .victim_fully_invalid (victim_fully_invalid)
  );

endmodule

FILE: design/pigv_checker.sv
module pigv_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              address_error,
  input logic                              page_was_valid,
  input logic                              victim_found,
  input logic [pigv_pkg::IDX_W-1:0]        victim_index,
  input logic [pigv_pkg::CNT_W-1:0]        victim_invalid_count,
  input logic                              victim_fully_invalid
);

  // one item at a time: a transfer in closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(victim_index) &&
      $stable(victim_invalid_count) && $stable(victim_found)))
    else $error("stalled result changed");

  // no victim means empty victim fields
  a_no_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !victim_found) |-> (victim_index == '0 &&
      victim_invalid_count == '0 && !victim_fully_invalid))
    else $error("victim fields set without a victim");

  // fully invalid only at a full block count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && victim_fully_invalid) |->
      (victim_invalid_count == pigv_pkg::CNT_W'(pigv_pkg::PAGES_PER_BLOCK)))
    else $error("fully invalid flag with partial count");

  // a rejected address never clears a page
  a_error_no_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && address_error) |-> !page_was_valid)
    else $error("page cleared on an address error");

endmodule

bind page_invalidation_greedy_victim_core pigv_checker u_checker (.*);
